### hw/rtl/pcid_pkg.sv
// ----------------------------------------------------------------------------
// pcid_pkg
// Shared types, constants and the reciprocal table of the packed color
// index decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pcid_pkg;

    localparam int IDX_W   = 64;
    localparam int COMP_W  = 16;
    localparam int NUM_W   = 32;
    localparam int BPC_W   = 5;
    localparam int MODE_W  = 2;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam int NLANE   = 3;
    localparam int NCOMP   = 4;
    localparam int NSTG    = 10;

    localparam logic [BPC_W-1:0] BPC_RESET = 5'd8;
    localparam logic [BPC_W-1:0] BPC_MAX   = 5'd16;

    typedef enum logic [MODE_W-1:0] {
        MODE_GRAY = 2'd0,
        MODE_RGB  = 2'd1,
        MODE_CMYK = 2'd2
    } t_mode;

    typedef enum logic {
        REG_MODE = 1'b0,
        REG_BPC  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [BPC_W-1:0]  bpc;
        logic [COMP_W-1:0] mask;
        logic [NUM_W-1:0]  recip;
        logic              one_bit;
    } t_cfg;

    // floor(2^32 / (2^b - 1)); width one uses the bypass path
    function automatic logic [NUM_W-1:0] recip_lut(input logic [BPC_W-1:0] b);
        logic [NUM_W-1:0] r;
        case (b)
            5'd2:    r = 32'h5555_5555;
            5'd3:    r = 32'h2492_4924;
            5'd4:    r = 32'h1111_1111;
            5'd5:    r = 32'h0842_1084;
            5'd6:    r = 32'h0410_4104;
            5'd7:    r = 32'h0204_0810;
            5'd8:    r = 32'h0101_0101;
            5'd9:    r = 32'h0080_4020;
            5'd10:   r = 32'h0040_1004;
            5'd11:   r = 32'h0020_0400;
            5'd12:   r = 32'h0010_0100;
            5'd13:   r = 32'h0008_0040;
            5'd14:   r = 32'h0004_0010;
            5'd15:   r = 32'h0002_0004;
            5'd16:   r = 32'h0001_0001;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/pcid_if.sv
// ----------------------------------------------------------------------------
// pcid_if
// Stream interfaces: packed pixel words in, RGB16 words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcid_pix_if;
    logic        valid;
    logic        ready;
    logic [63:0] color_index;

    modport source (output valid, output color_index, input ready);
    modport sink   (input valid, input color_index, output ready);
endinterface

interface pcid_rgb_if;
    logic        valid;
    logic        ready;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

### hw/rtl/pcid_cfg.sv
// ----------------------------------------------------------------------------
// pcid_cfg
// APB register file (mode, bits per component) and derived decode settings.
// ----------------------------------------------------------------------------
`default_nettype none

module pcid_cfg
    import pcid_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    logic [MODE_W-1:0] r_mode;
    logic [BPC_W-1:0]  r_bpc;
    logic [BPC_W-1:0]  bpc_eff;
    logic              wr_en;
    t_reg_idx          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_GRAY;
            r_bpc  <= BPC_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MODE: r_mode <= pwdata[MODE_W-1:0];
                REG_BPC:  r_bpc  <= pwdata[BPC_W-1:0];
                default:  r_mode <= r_mode;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MODE: prdata = {{(APB_DW-MODE_W){1'b0}}, r_mode};
            REG_BPC:  prdata = {{(APB_DW-BPC_W){1'b0}}, r_bpc};
            default:  prdata = '0;
        endcase
    end

    always_comb begin
        if (r_bpc == '0) begin
            bpc_eff = 5'd1;
        end else if (r_bpc > BPC_MAX) begin
            bpc_eff = BPC_MAX;
        end else begin
            bpc_eff = r_bpc;
        end
    end

    assign o_cfg.mode    = r_mode;
    assign o_cfg.bpc     = bpc_eff;
    assign o_cfg.mask    = COMP_W'((17'd1 << bpc_eff) - 17'd1);
    assign o_cfg.recip   = recip_lut(bpc_eff);
    assign o_cfg.one_bit = (bpc_eff == 5'd1);

endmodule

`default_nettype wire

### hw/rtl/pcid_unpack.sv
// ----------------------------------------------------------------------------
// pcid_unpack
// Splits the packed word into components, forms the two operands per lane
// and registers their product (two pipeline stages).
// ----------------------------------------------------------------------------
`default_nettype none

module pcid_unpack
    import pcid_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic [1:0]                   i_en,
    input  wire t_cfg                         i_cfg,
    input  wire logic [IDX_W-1:0]             i_idx,
    output logic      [NLANE-1:0][NUM_W-1:0]  o_num
);

    logic [NCOMP-1:0][COMP_W-1:0] comp;
    logic [NLANE-1:0][COMP_W-1:0] n_a;
    logic [NLANE-1:0][COMP_W-1:0] n_b;
    logic [NLANE-1:0][COMP_W-1:0] r_a;
    logic [NLANE-1:0][COMP_W-1:0] r_b;
    logic [NLANE-1:0][NUM_W-1:0]  r_num;

    always_comb begin
        logic [5:0] sh;
        for (int i = 0; i < NCOMP; i++) begin
            sh      = 6'(i) * {1'b0, i_cfg.bpc};
            comp[i] = COMP_W'(i_idx >> sh) & i_cfg.mask;
        end
    end

    always_comb begin
        logic [COMP_W-1:0] gray;
        gray = i_cfg.one_bit ? (i_cfg.mask - comp[0]) : comp[0];
        case (i_cfg.mode)
            MODE_RGB: begin
                n_a = {comp[0], comp[1], comp[2]};
                n_b = {i_cfg.mask, i_cfg.mask, i_cfg.mask};
            end
            MODE_CMYK: begin
                n_a = {i_cfg.mask - comp[1], i_cfg.mask - comp[2], i_cfg.mask - comp[3]};
                n_b = {NLANE{i_cfg.mask - comp[0]}};
            end
            default: begin
                n_a = {NLANE{gray}};
                n_b = {NLANE{i_cfg.mask}};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a <= n_a;
            r_b <= n_b;
        end
        if (i_en[1]) begin
            for (int i = 0; i < NLANE; i++) begin
                r_num[i] <= NUM_W'(r_a[i]) * NUM_W'(r_b[i]);
            end
        end
    end

    assign o_num = r_num;

endmodule

`default_nettype wire

### hw/rtl/pcid_div.sv
// ----------------------------------------------------------------------------
// pcid_div
// Three-stage divide by the component mask: reciprocal multiply, back
// multiply, one-step correction. Quotient fits 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pcid_div
    import pcid_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic [2:0]        i_en,
    input  wire t_cfg              i_cfg,
    input  wire logic [NUM_W-1:0]  i_num,
    output logic      [COMP_W-1:0] o_quo
);

    logic [2*NUM_W-1:0] prod;
    logic [NUM_W-1:0]   rem;
    logic [NUM_W-1:0]   r_num1;
    logic [NUM_W-1:0]   r_num2;
    logic [COMP_W-1:0]  r_qe1;
    logic [COMP_W-1:0]  r_qe2;
    logic [NUM_W-1:0]   r_qm;
    logic [COMP_W-1:0]  r_quo;

    assign prod = (2*NUM_W)'(i_num) * (2*NUM_W)'(i_cfg.recip);
    assign rem  = r_num2 - r_qm;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_num1 <= i_num;
            r_qe1  <= prod[NUM_W+COMP_W-1:NUM_W];
        end
        if (i_en[1]) begin
            r_num2 <= r_num1;
            r_qe2  <= r_qe1;
            r_qm   <= NUM_W'(r_qe1) * NUM_W'(i_cfg.mask);
        end
        if (i_en[2]) begin
            if (i_cfg.one_bit) begin
                r_quo <= r_num2[COMP_W-1:0];
            end else begin
                r_quo <= r_qe2 + COMP_W'(rem >= NUM_W'(i_cfg.mask));
            end
        end
    end

    assign o_quo = r_quo;

endmodule

`default_nettype wire

### hw/rtl/packed_color_index_decoder_unit.sv
// ----------------------------------------------------------------------------
// packed_color_index_decoder_unit
// Packed pixel word to 16-bit red, green and blue.
//
// i_pix carries one packed color index per word; o_rgb returns one RGB16
// word for each, in order. Mode and bits per component must be set over the
// APB port only while no word is in flight; the block does not enforce it.
// Ten register stages: unpack, operand product, divide by mask (three
// stages), scale by 65535, divide by mask (three stages), output register.
// One word per cycle is accepted and delivered while o_rgb is not stalled.
// Every stage has its own valid bit and loads when it is empty or its
// successor loads, so bubbles close up while o_rgb is stalled and words keep
// entering until the pipeline is full; nothing is dropped or repeated.
// Synchronous reset empties the pipeline and sets gray mode, 8 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_color_index_decoder_unit
    import pcid_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    pcid_pix_if.sink               i_pix,
    pcid_rgb_if.source             o_rgb,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    t_cfg                        cfg;
    logic [NSTG-1:0]             r_vld;
    logic [NSTG-1:0]             en;
    logic [NLANE-1:0][NUM_W-1:0]  num1;
    logic [NLANE-1:0][COMP_W-1:0] q1;
    logic [NLANE-1:0][NUM_W-1:0]  r_num2;
    logic [NLANE-1:0][COMP_W-1:0] q2;
    logic [NLANE-1:0][COMP_W-1:0] r_out;

    pcid_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || o_rgb.ready;
        for (int k = NSTG-2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    pcid_unpack u_unpack (
        .i_clk (i_clk),
        .i_en  (en[1:0]),
        .i_cfg (cfg),
        .i_idx (i_pix.color_index),
        .o_num (num1)
    );

    for (genvar g = 0; g < NLANE; g++) begin : g_lane
        pcid_div u_div1 (
            .i_clk (i_clk),
            .i_en  (en[4:2]),
            .i_cfg (cfg),
            .i_num (num1[g]),
            .o_quo (q1[g])
        );

        pcid_div u_div2 (
            .i_clk (i_clk),
            .i_en  (en[8:6]),
            .i_cfg (cfg),
            .i_num (r_num2[g]),
            .o_quo (q2[g])
        );
    end

    // x * 65535 as (x << 16) - x
    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            for (int i = 0; i < NLANE; i++) begin
                r_num2[i] <= {q1[i], {COMP_W{1'b0}}} - NUM_W'(q1[i]);
            end
        end
        if (en[NSTG-1]) begin
            r_out <= q2;
        end
    end

    assign i_pix.ready = en[0];
    assign o_rgb.valid = r_vld[NSTG-1];
    assign o_rgb.red   = r_out[0];
    assign o_rgb.green = r_out[1];
    assign o_rgb.blue  = r_out[2];

endmodule

`default_nettype wire

### hw/rtl/pcid_chk.sv
// ----------------------------------------------------------------------------
// pcid_chk
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pcid_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [47:0] i_out_data
);

    a_empty_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result word present right after reset");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input held off while output stage is empty");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result word changed or dropped");

    a_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready && !i_in_ready |=> !i_in_ready || i_out_ready
            || !$past(i_out_valid && !i_out_ready))
        else $error("input reopened while pipeline full and stalled");

endmodule

bind packed_color_index_decoder_unit pcid_chk u_pcid_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready),
    .i_out_data  ({o_rgb.red, o_rgb.green, o_rgb.blue})
);

`default_nettype wire
